FILE: src/keyed_fixed_window_rate_limiter_defines.svh
// Assertion macros shared by the rate limiter modules.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef KEYED_FIXED_WINDOW_RATE_LIMITER_DEFINES_SVH
`define KEYED_FIXED_WINDOW_RATE_LIMITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KFWRL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KFWRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/kfwrl_pkg.sv
`timescale 1ns / 1ps

package kfwrl_pkg;

	localparam int TBL_ENTRIES = 1024;
	localparam int IDX_W       = (TBL_ENTRIES > 1) ? $clog2(TBL_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(TBL_ENTRIES + 1);

	localparam int KEY_W  = 64;
	localparam int TIME_W = 32;
	localparam int RCNT_W = 16;
	localparam int LIM_W  = 16;
	localparam int WIN_W  = 16;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_LIMIT  = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	localparam logic             ENABLE_RST = 1'b1;
	localparam logic [LIM_W-1:0] LIMIT_RST  = 16'd20;
	localparam logic [WIN_W-1:0] WINDOW_RST = 16'd60;

	localparam logic [RCNT_W-1:0] RCNT_MAX = {RCNT_W{1'b1}};

	typedef struct packed {
		logic [KEY_W-1:0]  card_key;
		logic [TIME_W-1:0] now_time;
	} kfwrl_req_t;

	typedef struct packed {
		logic              allowed;
		logic [RCNT_W-1:0] request_count;
	} kfwrl_res_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] opened_at;
		logic [RCNT_W-1:0] count;
	} kfwrl_entry_t;

	localparam int ENTRY_W = $bits(kfwrl_entry_t);

	typedef struct packed {
		logic             limiter_enable;
		logic [LIM_W-1:0] request_limit;
		logic [WIN_W-1:0] window_length;
	} kfwrl_cfg_t;

	typedef struct packed {
		logic             load;
		logic             bypass;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             cmp_en;
		logic [IDX_W-1:0] cmp_idx;
		logic             pick;
		logic             commit;
	} kfwrl_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] fill;
	} kfwrl_sts_t;

endpackage

FILE: src/kfwrl_ram.sv
`timescale 1ns / 1ps

module kfwrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/kfwrl_regs.sv
`timescale 1ns / 1ps

module kfwrl_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [kfwrl_pkg::PADDR_W-1:0]      paddr,
	input  logic [kfwrl_pkg::PDATA_W-1:0]      pwdata,
	output logic [kfwrl_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready,
	output kfwrl_pkg::kfwrl_cfg_t              cfg
);

	import kfwrl_pkg::*;

	kfwrl_cfg_t cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limiter_enable <= ENABLE_RST;
			cfg_q.request_limit  <= LIMIT_RST;
			cfg_q.window_length  <= WINDOW_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ENABLE: cfg_q.limiter_enable <= pwdata[0];
				REG_LIMIT:  cfg_q.request_limit  <= pwdata[LIM_W-1:0];
				REG_WINDOW: cfg_q.window_length  <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_ENABLE: prdata[0]         = cfg_q.limiter_enable;
			REG_LIMIT:  prdata[LIM_W-1:0] = cfg_q.request_limit;
			REG_WINDOW: prdata[WIN_W-1:0] = cfg_q.window_length;
			default:    prdata            = '0;
		endcase
	end

endmodule

FILE: src/kfwrl_dp.sv
`timescale 1ns / 1ps
`include "keyed_fixed_window_rate_limiter_defines.svh"

module kfwrl_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  kfwrl_pkg::kfwrl_cmd_t   cmd,
	input  kfwrl_pkg::kfwrl_cfg_t   cfg,
	input  kfwrl_pkg::kfwrl_req_t   req,
	output kfwrl_pkg::kfwrl_sts_t   sts,
	output logic                    done,
	output kfwrl_pkg::kfwrl_res_t   res
);

	import kfwrl_pkg::*;

	// Slots are claimed in index order and never freed, so the valid slots
	// always form a prefix of the table whose length is the fill count.
	logic [CNT_W-1:0]  fill_q;

	kfwrl_req_t        req_q;
	logic              match_found_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic [TIME_W-1:0] match_ws_q;
	logic [RCNT_W-1:0] match_cnt_q;
	logic              old_found_q;
	logic [IDX_W-1:0]  old_idx_q;
	logic [TIME_W-1:0] oldest_q;

	logic [IDX_W-1:0]  pick_idx_q;
	logic [TIME_W-1:0] base_ws_q;
	logic [RCNT_W-1:0] base_cnt_q;
	logic              claim_free_q;

	logic              res_vld_q;
	kfwrl_res_t        res_q;

	logic [ENTRY_W-1:0] rdata;
	kfwrl_entry_t       rd_entry;
	kfwrl_entry_t       wr_entry;
	logic               table_full;

	logic [TIME_W-1:0] age;
	logic              restart;
	logic [RCNT_W-1:0] cnt_base;
	logic [RCNT_W-1:0] cnt_new;
	logic [TIME_W-1:0] ws_new;

	assign rd_entry   = rdata;
	assign table_full = (fill_q == CNT_W'(TBL_ENTRIES));
	assign sts.fill   = fill_q;
	assign done       = res_vld_q;
	assign res        = res_q;

	kfwrl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TBL_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(pick_idx_q),
		.wdata(wr_entry),
		.re   (cmd.rd_en),
		.raddr(cmd.rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		age      = req_q.now_time - base_ws_q;
		restart  = (age >= {{(TIME_W - WIN_W){1'b0}}, cfg.window_length});
		cnt_base = restart ? '0 : base_cnt_q;
		ws_new   = restart ? req_q.now_time : base_ws_q;
		cnt_new  = (cnt_base == RCNT_MAX) ? RCNT_MAX : cnt_base + RCNT_W'(1);
		wr_entry.key       = req_q.card_key;
		wr_entry.opened_at = ws_new;
		wr_entry.count     = cnt_new;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q         <= req;
			match_found_q <= 1'b0;
			old_found_q   <= 1'b0;
			oldest_q      <= req.now_time;
			match_idx_q   <= '0;
			old_idx_q     <= '0;
		end else if (cmd.cmp_en) begin
			if (!match_found_q && rd_entry.key == req_q.card_key) begin
				match_found_q <= 1'b1;
				match_idx_q   <= cmd.cmp_idx;
				match_ws_q    <= rd_entry.opened_at;
				match_cnt_q   <= rd_entry.count;
			end
			if (rd_entry.opened_at < oldest_q) begin
				old_found_q <= 1'b1;
				old_idx_q   <= cmd.cmp_idx;
				oldest_q    <= rd_entry.opened_at;
			end
		end

		if (cmd.pick) begin
			claim_free_q <= 1'b0;
			base_ws_q    <= req_q.now_time;
			base_cnt_q   <= '0;
			if (match_found_q) begin
				pick_idx_q <= match_idx_q;
				base_ws_q  <= match_ws_q;
				base_cnt_q <= match_cnt_q;
			end else if (!table_full) begin
				pick_idx_q   <= fill_q[IDX_W-1:0];
				claim_free_q <= 1'b1;
			end else if (old_found_q) begin
				pick_idx_q <= old_idx_q;
			end else begin
				pick_idx_q <= '0;
			end
		end

		if (cmd.bypass) begin
			res_q.allowed       <= 1'b1;
			res_q.request_count <= '0;
		end else if (cmd.commit) begin
			res_q.allowed       <= (cnt_new <= cfg.request_limit);
			res_q.request_count <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= cmd.bypass | cmd.commit;
			if (cmd.commit && claim_free_q) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	`KFWRL_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CNT_W'(TBL_ENTRIES), "fill count beyond table")
	`KFWRL_ASSERT_NEXT(a_commit_beat, cmd.commit || cmd.bypass, res_vld_q, "result beat missing")

endmodule

FILE: src/kfwrl_ctrl.sv
`timescale 1ns / 1ps
`include "keyed_fixed_window_rate_limiter_defines.svh"

module kfwrl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  enable,
	input  kfwrl_pkg::kfwrl_sts_t sts,
	output logic                  busy,
	output kfwrl_pkg::kfwrl_cmd_t cmd
);

	import kfwrl_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_PICK   = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       state_nxt;
	logic [CNT_W-1:0] addr_q;
	logic [CNT_W-1:0] addr_inc;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             accept;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && (state_q == ST_IDLE);
	assign addr_inc = addr_q + CNT_W'(1);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && enable) begin
					state_nxt = (sts.fill == '0) ? ST_PICK : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (addr_inc == sts.fill) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_nxt = ST_PICK;
			ST_PICK:   state_nxt = ST_COMMIT;
			ST_COMMIT: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = accept && enable;
		cmd.bypass  = accept && !enable;
		cmd.rd_en   = (state_q == ST_SCAN);
		cmd.rd_addr = addr_q[IDX_W-1:0];
		cmd.cmp_en  = cmp_vld_s1;
		cmd.cmp_idx = cmp_idx_s1;
		cmd.pick    = (state_q == ST_PICK);
		cmd.commit  = (state_q == ST_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			addr_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			state_q <= state_nxt;
			// Read data returns in the cycle after the address, so the index
			// travels alongside it.
			cmp_vld_s1 <= (state_q == ST_SCAN);
			cmp_idx_s1 <= addr_q[IDX_W-1:0];
			if (state_q == ST_SCAN) begin
				addr_q <= addr_inc;
			end else begin
				addr_q <= '0;
			end
		end
	end

	`KFWRL_ASSERT_NOW(a_scan_in_fill, state_q == ST_SCAN, addr_q < sts.fill, "scan past fill")
	`KFWRL_ASSERT_NEXT(a_pick_commit, state_q == ST_PICK, state_q == ST_COMMIT, "pick without commit")

endmodule

FILE: src/keyed_fixed_window_rate_limiter.sv
`timescale 1ns / 1ps

// Keyed fixed-window rate limiter. A request is taken when start is high and
// busy is low; its result appears on res for exactly one cycle with done high,
// and the receiver cannot stall it, so it must capture the beat when it comes.
// With the limiter disabled the result follows in the next cycle and busy stays
// low. Otherwise the block scans the occupied slots of the table, one slot per
// cycle, then drains and goes through pick and commit; scan and drain are
// skipped with an empty table. The result shows in the cycle busy falls. No
// clearing pass is needed after reset. The user must see that configuration
// is written via the APB port only while the block is idle (not enforced).
module keyed_fixed_window_rate_limiter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  kfwrl_pkg::kfwrl_req_t          req,
	output logic                           done,
	output kfwrl_pkg::kfwrl_res_t          res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [kfwrl_pkg::PADDR_W-1:0]  paddr,
	input  logic [kfwrl_pkg::PDATA_W-1:0]  pwdata,
	output logic [kfwrl_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready
);

	import kfwrl_pkg::*;

	kfwrl_cfg_t cfg;
	kfwrl_cmd_t cmd;
	kfwrl_sts_t sts;

	kfwrl_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	kfwrl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.enable(cfg.limiter_enable),
		.sts   (sts),
		.busy  (busy),
		.cmd   (cmd)
	);

	kfwrl_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.cfg   (cfg),
		.req   (req),
		.sts   (sts),
		.done  (done),
		.res   (res)
	);

endmodule
